FILE: rtl/kss_pkg.sv
// Package: shared types, codes and defaults for the shared-store stack block.
package kss_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int STACKS_DEF = 8;

    localparam int CMD_W    = 1;
    localparam int SID_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;       // input transfer: latch item, read memories
        logic commit;     // write back pointers, load result register
        logic use_input;  // memory read address comes from the incoming item
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

FILE: rtl/k_stacks_shared_store.sv
// The input transfer latches the item and reads the memories; the result register loads
// when the exec state commits, which waits while a result not yet taken blocks the register.
// Each operation: link/entry memory read, then write-back; the next is taken after commit.
// The result register frees the input side while a result waits to be taken.
// Reset: synchronous active-low; stacks empty, free list 0..DEPTH-1 via a fill mark,
// so no clearing pass is needed and operations are accepted right after reset.
module k_stacks_shared_store
    import kss_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int STACKS = STACKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [SID_W-1:0]         i_stack_id,
    input  logic signed [VAL_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [VAL_W-1:0]  o_popped_value
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    kss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kss_datapath #(
        .DEPTH  (DEPTH),
        .STACKS (STACKS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_command      (i_command),
        .i_stack_id     (i_stack_id),
        .i_value        (i_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value)
    );

endmodule

FILE: rtl/kss_ctrl.sv
// Controller: two-state sequencer for read and write-back of one operation.
module kss_ctrl
    import kss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.commit     = 1'b0;
        o_cmd.use_input  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.use_input = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register must be free or draining this cycle
                if (!i_stat.out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("load did not enter exec");

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE))
        else $error("commit did not return to idle");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_stat.out_valid && !i_out_ready) |=> (r_state == S_EXEC))
        else $error("exec left while result register blocked");

endmodule

FILE: rtl/kss_datapath.sv
// Datapath: entry and link memories, stack tops, free list head and result register.
module kss_datapath
    import kss_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int STACKS = STACKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctrl_cmd                  i_cmd,
    output t_dp_stat                   o_stat,
    input  logic [CMD_W-1:0]           i_command,
    input  logic [SID_W-1:0]           i_stack_id,
    input  logic signed [VAL_W-1:0]    i_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VAL_W-1:0]    o_popped_value
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(DEPTH);

    logic [VAL_W-1:0] r_entry_mem [DEPTH];
    logic [PW-1:0]    r_link_mem  [DEPTH];

    logic [PW-1:0] r_top [STACKS];
    logic [PW-1:0] r_free_head;
    // entries at or above r_fill were never handed out: their link is index+1
    logic [PW-1:0] r_fill;

    logic [CMD_W-1:0]  r_command;
    logic [SW-1:0]     r_sidx;
    logic [VAL_W-1:0]  r_value;
    logic [PW-1:0]     r_slot;
    logic              r_slot_ok;

    logic [PW-1:0]     r_link_rd;
    logic [VAL_W-1:0]  r_entry_rd;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [VAL_W-1:0]      r_popped;

    logic          sid_ok;
    logic [SW-1:0] sidx;
    logic [PW-1:0] top_sel;
    logic [PW-1:0] slot_c;
    logic          slot_ok_c;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] link_raw;
    logic [PW-1:0] link_eff;
    logic [PW-1:0] slot_inc;
    logic          do_write;
    logic          is_push;

    // item decode at the input transfer
    always_comb begin
        sid_ok  = (32'(i_stack_id) < STACKS);
        sidx    = SW'(i_stack_id);
        top_sel = sid_ok ? r_top[sidx] : NULL_PTR;
        if (i_command == CMD_PUSH) begin
            slot_c    = r_free_head;
            slot_ok_c = sid_ok && (r_free_head < NULL_PTR);
        end else begin
            slot_c    = top_sel;
            slot_ok_c = sid_ok && (top_sel < NULL_PTR);
        end
        rd_addr = i_cmd.use_input ? AW'(slot_c) : AW'(r_slot);
        wr_addr = AW'(r_slot);
    end

    // link of the selected entry, with untouched entries reading as index+1
    always_comb begin
        slot_inc = r_slot + PW'(1);
        link_raw = (r_slot >= r_fill) ? slot_inc : r_link_rd;
        link_eff = (link_raw >= NULL_PTR) ? NULL_PTR : link_raw;
        is_push  = (r_command == CMD_PUSH);
        do_write = i_cmd.commit && r_slot_ok;
    end

    always_ff @(posedge i_clk) begin
        r_link_rd  <= r_link_mem[rd_addr];
        r_entry_rd <= r_entry_mem[rd_addr];
        if (do_write) begin
            if (is_push) begin
                r_entry_mem[wr_addr] <= r_value;
                r_link_mem[wr_addr]  <= r_top[r_sidx];
            end else begin
                r_link_mem[wr_addr]  <= r_free_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_sidx    <= sidx;
            r_value   <= i_value;
            r_slot    <= slot_c;
        end
        if (i_cmd.commit) begin
            r_popped <= (r_slot_ok && !is_push) ? r_entry_rd : '0;
            if (r_slot_ok) begin
                r_status <= ST_OK;
            end else begin
                r_status <= is_push ? ST_OVERFLOW : ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STACKS; s++) begin
                r_top[s] <= NULL_PTR;
            end
            r_free_head <= '0;
            r_fill      <= '0;
            r_slot_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_slot_ok <= slot_ok_c;
            end
            if (do_write) begin
                if (is_push) begin
                    r_top[r_sidx] <= r_slot;
                    r_free_head   <= link_eff;
                    if (r_slot >= r_fill) begin
                        r_fill <= slot_inc;
                    end
                end else begin
                    r_top[r_sidx] <= link_eff;
                    r_free_head   <= r_slot;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_popped_value   = r_popped;

    a_commit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not load result register");

    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= NULL_PTR)
        else $error("free head out of range");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= NULL_PTR) && ((r_free_head == NULL_PTR) || (r_free_head <= r_fill)))
        else $error("free head points beyond the fill mark");

endmodule

FILE: sim/tb.sv
// Testbench for k_stacks_shared_store: directed table, biased random fill/drain, scoreboard.
module tb;
    import kss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STACKS      = STACKS_DEF;
    localparam int NUM_DIR     = 20;
    localparam int PHASE_ITEMS = 540;
    localparam int FILL_ITEMS  = 350;
    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam logic [8:0] NULL_PTR = 9'(DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    popped;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SID_W-1:0]    sid;
        logic [VAL_W-1:0]    val;
        logic                typed;   // expected result given in the row
        logic [STATUS_W-1:0] st;
        logic [VAL_W-1:0]    pv;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_command = CMD_PUSH;
    logic [SID_W-1:0]        i_stack_id = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic signed [VAL_W-1:0] o_popped_value;

    k_stacks_shared_store #(
        .DEPTH (DEPTH),
        .STACKS(STACKS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_stack_id    (i_stack_id),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_popped_value(o_popped_value)
    );

    // shadow copy of the shared store
    logic [VAL_W-1:0] slot_data [DEPTH];
    logic [8:0]       slot_next [DEPTH];
    logic [8:0]       top_ptr   [STACKS];
    logic [8:0]       free_ptr;

    t_result pending_res[$];
    t_row    dir_rows [NUM_DIR];

    int  n_err = 0;
    int  n_push_ok = 0, n_pop_ok = 0, n_overflow = 0, n_empty = 0, n_results = 0;
    int  tx_idle_pct = 27;
    int  rx_idle_pct = 52;
    int  stall_cnt = 0;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        n_err++;
    endtask

    // Applies one operation to the shadow store and returns the result it produces.
    task automatic stack_apply(input logic [CMD_W-1:0] cmd, input logic [SID_W-1:0] sid,
                               input logic [VAL_W-1:0] val, output t_result res);
        logic [8:0] slot;
        logic [8:0] nxt;
        res = '0;
        if (cmd == CMD_PUSH) begin
            if (int'(sid) >= STACKS || free_ptr >= NULL_PTR) begin
                res.status = ST_OVERFLOW;
                n_overflow++;
            end else begin
                slot            = free_ptr;
                nxt             = slot_next[slot];
                slot_data[slot] = val;
                slot_next[slot] = top_ptr[sid];
                top_ptr[sid]    = slot;
                free_ptr        = (nxt >= NULL_PTR) ? NULL_PTR : nxt;
                res.status      = ST_OK;
                n_push_ok++;
            end
        end else begin
            if (int'(sid) >= STACKS || top_ptr[sid] >= NULL_PTR) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else begin
                slot            = top_ptr[sid];
                nxt             = slot_next[slot];
                res.popped      = slot_data[slot];
                top_ptr[sid]    = (nxt >= NULL_PTR) ? NULL_PTR : nxt;
                slot_next[slot] = free_ptr;
                free_ptr        = slot;
                res.status      = ST_OK;
                n_pop_ok++;
            end
        end
    endtask

    // Offers one operation, holds it until the transfer, then queues its expected result.
    task automatic send_op(input t_row row);
        t_result res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command  <= row.cmd;
        i_stack_id <= row.sid;
        i_value    <= row.val;
        do @(posedge i_clk); while (!o_in_ready);
        stack_apply(row.cmd, row.sid, row.val, res);
        if (row.typed) begin
            res.status = row.st;
            res.popped = row.pv;
        end
        pending_res.push_back(res);
    endtask

    // Sender goes quiet until every outstanding result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_res.size() == 0);
    endtask

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result, status/value",
                                {30'd0, o_status}, o_popped_value);
            end else begin
                want = pending_res.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
                if (o_popped_value !== want.popped)
                    report_mismatch("popped_value", o_popped_value, want.popped);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt + 1 >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int   tx_pct [3];
        int   rx_pct [3];
        t_row row;
        int   pick;

        tx_pct = '{27, 52, 0};
        rx_pct = '{52, 27, 0};

        for (int i = 0; i < DEPTH; i++) begin
            slot_data[i] = '0;
            slot_next[i] = 9'(i + 1);
        end
        for (int s = 0; s < STACKS; s++) top_ptr[s] = NULL_PTR;
        free_ptr = '0;

        dir_rows = '{
            '{CMD_POP,  3'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{CMD_POP,  3'd7, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{CMD_PUSH, 3'd0, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
            '{CMD_PUSH, 3'd0, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{CMD_PUSH, 3'd7, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
            '{CMD_PUSH, 3'd7, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{CMD_PUSH, 3'd3, 32'hA5A5_A5A5, 1'b1, ST_OK,    32'h0000_0000},
            '{CMD_POP,  3'd0, 32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000},
            '{CMD_POP,  3'd0, 32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF},
            '{CMD_POP,  3'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{CMD_POP,  3'd7, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{CMD_POP,  3'd7, 32'h0000_0000, 1'b1, ST_OK,    32'hFFFF_FFFF},
            '{CMD_PUSH, 3'd5, 32'h5A5A_5A5A, 1'b1, ST_OK,    32'h0000_0000},
            // value field must be ignored on a pop
            '{CMD_POP,  3'd3, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'hA5A5_A5A5},
            '{CMD_PUSH, 3'd1, 32'h0000_0001, 1'b0, ST_OK,    32'h0000_0000},
            '{CMD_PUSH, 3'd2, 32'h1234_5678, 1'b0, ST_OK,    32'h0000_0000},
            '{CMD_POP,  3'd5, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
            '{CMD_POP,  3'd1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
            '{CMD_POP,  3'd2, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
            '{CMD_POP,  3'd2, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_op(dir_rows[r]);
        drain_results();

        // each phase: push-heavy for the first FILL_ITEMS items so the store overflows, then pop-heavy
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 100) hold_go = 1'b1;
                row       = '0;
                row.cmd   = ($urandom_range(0, 99) < ((k < FILL_ITEMS) ? 95 : 15))
                            ? CMD_PUSH : CMD_POP;
                row.sid   = ($urandom_range(0, 3) == 0) ? SID_W'($urandom_range(0, 1))
                                                        : SID_W'($urandom_range(0, 7));
                pick      = $urandom_range(0, 19);
                case (pick)
                    0:       row.val = 32'h7FFF_FFFF;
                    1:       row.val = 32'h8000_0000;
                    2:       row.val = 32'hFFFF_FFFF;
                    3:       row.val = 32'h0000_0000;
                    default: row.val = $urandom;
                endcase
                send_op(row);
            end
            drain_results();
        end

        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d results: %0d pushes, %0d pops, %0d overflows, %0d empty pops",
                 n_results, n_push_ok, n_pop_ok, n_overflow, n_empty);
        $display("three stall mixes plus a %0d-cycle output hold-off; %0d mismatches",
                 HOLD_CYCLES, n_err);
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
